[design/mdg_pkg.sv]
// ----------------------------------------------------------------------------
// mdg_pkg
// Shared types and codes for the maze dig generator.
// ----------------------------------------------------------------------------
package mdg_pkg;

    localparam int COORD_W = 6;   // coordinate field width
    localparam int XW      = 9;   // widened coordinate for border arithmetic
    localparam int CFG_W   = 7;   // size register width

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STEP  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] ST_STARTED   = 3'd0;
    localparam logic [2:0] ST_CARVED    = 3'd1;
    localparam logic [2:0] ST_BACKTRACK = 3'd2;
    localparam logic [2:0] ST_FINISHED  = 3'd3;
    localparam logic [2:0] ST_READ      = 3'd4;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        RSEL_C  = 3'd0,   // digger row
        RSEL_U1 = 3'd1,
        RSEL_U2 = 3'd2,
        RSEL_D1 = 3'd3,
        RSEL_D2 = 3'd4,
        RSEL_Q  = 3'd5    // row asked for by a read
    } t_row_sel;

    typedef enum logic [4:0] {
        S_CLR_RST,
        S_IDLE,
        S_CLR_START,
        S_START,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_RD4,
        S_RD5,
        S_DECIDE,
        S_CARVE1,
        S_CARVE2,
        S_MOVE,
        S_POP_RD,
        S_POP_WR,
        S_RQ,
        S_RQW,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     load_item;
        logic     clr_row;
        logic     start_wr;
        logic     rd_en;
        t_row_sel rd_sel;
        logic     cap_en;
        t_row_sel cap_sel;
        logic     decide;
        logic     carve1;
        logic     carve2;
        logic     move;
        logic     pop_rd;
        logic     pop_wr;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic level_zero;
        logic clr_last;
        logic no_move;
        logic vertical;
        logic out_busy;
    } t_dp_stat;

endpackage

[design/mdg_in_if.sv]
// ----------------------------------------------------------------------------
// mdg_in_if
// Item channel: opcode, random word and read coordinates.
// ----------------------------------------------------------------------------
interface mdg_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [15:0] random_value;
    logic [5:0] read_row;
    logic [5:0] read_col;

    modport source (output valid, output opcode, output random_value,
                    output read_row, output read_col, input ready);
    modport sink   (input valid, input opcode, input random_value,
                    input read_row, input read_col, output ready);
endinterface

[design/mdg_out_if.sv]
// ----------------------------------------------------------------------------
// mdg_out_if
// Result channel: status, digger position, direction and cell reply.
// ----------------------------------------------------------------------------
interface mdg_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [5:0] digger_row;
    logic [5:0] digger_col;
    logic [1:0] move_dir;
    logic       cell_is_wall;

    modport source (output valid, output status, output digger_row,
                    output digger_col, output move_dir, output cell_is_wall,
                    input ready);
    modport sink   (input valid, input status, input digger_row,
                    input digger_col, input move_dir, input cell_is_wall,
                    output ready);
endinterface

[design/mdg_ctrl.sv]
// ----------------------------------------------------------------------------
// mdg_ctrl
// Sequencer: steps the datapath through clear, dig, backtrack and read.
// ----------------------------------------------------------------------------
module mdg_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_opcode,
    output logic              o_in_ready,
    input  mdg_pkg::t_dp_stat i_stat,
    output mdg_pkg::t_dp_cmd  o_cmd
);

    mdg_pkg::t_state r_state;
    mdg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdg_pkg::S_CLR_RST;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.rd_sel  = mdg_pkg::RSEL_C;
        o_cmd.cap_sel = mdg_pkg::RSEL_C;
        case (r_state)
            mdg_pkg::S_CLR_RST: begin
                o_cmd.clr_row = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = mdg_pkg::S_IDLE;
                end
            end
            mdg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    case (i_opcode)
                        mdg_pkg::OP_START: n_state = mdg_pkg::S_CLR_START;
                        mdg_pkg::OP_STEP:  n_state = i_stat.level_zero ?
                                                     mdg_pkg::S_DONE : mdg_pkg::S_RD0;
                        default:           n_state = mdg_pkg::S_RQ;
                    endcase
                end
            end
            mdg_pkg::S_CLR_START: begin
                o_cmd.clr_row = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = mdg_pkg::S_START;
                end
            end
            mdg_pkg::S_START: begin
                o_cmd.start_wr = 1'b1;
                n_state = mdg_pkg::S_DONE;
            end
            mdg_pkg::S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = mdg_pkg::RSEL_C;
                n_state = mdg_pkg::S_RD1;
            end
            mdg_pkg::S_RD1: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = mdg_pkg::RSEL_U1;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mdg_pkg::RSEL_C;
                n_state = mdg_pkg::S_RD2;
            end
            mdg_pkg::S_RD2: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = mdg_pkg::RSEL_U2;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mdg_pkg::RSEL_U1;
                n_state = mdg_pkg::S_RD3;
            end
            mdg_pkg::S_RD3: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = mdg_pkg::RSEL_D1;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mdg_pkg::RSEL_U2;
                n_state = mdg_pkg::S_RD4;
            end
            mdg_pkg::S_RD4: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = mdg_pkg::RSEL_D2;
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mdg_pkg::RSEL_D1;
                n_state = mdg_pkg::S_RD5;
            end
            mdg_pkg::S_RD5: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mdg_pkg::RSEL_D2;
                n_state = mdg_pkg::S_DECIDE;
            end
            mdg_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_stat.no_move ? mdg_pkg::S_POP_RD : mdg_pkg::S_CARVE1;
            end
            mdg_pkg::S_CARVE1: begin
                o_cmd.carve1 = 1'b1;
                n_state = i_stat.vertical ? mdg_pkg::S_CARVE2 : mdg_pkg::S_MOVE;
            end
            mdg_pkg::S_CARVE2: begin
                o_cmd.carve2 = 1'b1;
                n_state = mdg_pkg::S_MOVE;
            end
            mdg_pkg::S_MOVE: begin
                o_cmd.move = 1'b1;
                n_state = mdg_pkg::S_DONE;
            end
            mdg_pkg::S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state = mdg_pkg::S_POP_WR;
            end
            mdg_pkg::S_POP_WR: begin
                o_cmd.pop_wr = 1'b1;
                n_state = mdg_pkg::S_DONE;
            end
            mdg_pkg::S_RQ: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = mdg_pkg::RSEL_Q;
                n_state = mdg_pkg::S_RQW;
            end
            mdg_pkg::S_RQW: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = mdg_pkg::RSEL_C;
                n_state = mdg_pkg::S_DONE;
            end
            mdg_pkg::S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state = mdg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mdg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/mdg_datapath.sv]
// ----------------------------------------------------------------------------
// mdg_datapath
// Wall map (one row per word), branch stack, digger position and result reg.
// ----------------------------------------------------------------------------
module mdg_datapath #(
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_HEIGHT  = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [mdg_pkg::CFG_W-1:0] i_cfg_wdata,
    input  mdg_pkg::t_dp_cmd          i_cmd,
    output mdg_pkg::t_dp_stat         o_stat,
    input  logic [1:0]                i_opcode,
    input  logic [15:0]               i_random_value,
    input  logic [5:0]                i_read_row,
    input  logic [5:0]                i_read_col,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [2:0]                o_status,
    output logic [5:0]                o_digger_row,
    output logic [5:0]                o_digger_col,
    output logic [1:0]                o_move_dir,
    output logic                      o_cell_is_wall
);

    localparam int AW = $clog2(MAX_HEIGHT);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int XW = mdg_pkg::XW;
    localparam int PW = mdg_pkg::COORD_W;

    typedef logic [MAX_WIDTH-1:0] t_row;

    // a column beyond the stored row reads as wall
    function automatic logic wall_at(input t_row row, input logic [XW-1:0] idx);
        if (idx >= XW'(MAX_WIDTH)) begin
            return 1'b1;
        end
        return row[idx[CW-1:0]];
    endfunction

    function automatic t_row open_at(input t_row row, input logic [XW-1:0] idx);
        t_row res;
        res = row;
        if (idx < XW'(MAX_WIDTH)) begin
            res[idx[CW-1:0]] = 1'b0;
        end
        return res;
    endfunction

    // 16-bit value modulo 3 via base-4 digit sums
    function automatic logic [1:0] mod3(input logic [15:0] v);
        logic [4:0] s;
        logic [2:0] t;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (t >= 3'd6) begin
            t = t - 3'd6;
        end else if (t >= 3'd3) begin
            t = t - 3'd3;
        end
        return t[1:0];
    endfunction

    // configuration
    logic [mdg_pkg::CFG_W-1:0] r_maze_width;
    logic [mdg_pkg::CFG_W-1:0] r_maze_height;

    // item
    logic [15:0]   r_rnd;
    logic [PW-1:0] r_rd_row;
    logic [PW-1:0] r_rd_col;

    // digger and stack
    logic [PW-1:0] r_cur_row;
    logic [PW-1:0] r_cur_col;
    logic [LW-1:0] r_level;
    logic [2*PW-1:0] r_stack [STACK_DEPTH];
    logic [2*PW-1:0] r_stk_rdata;

    // map
    t_row          r_map [MAX_HEIGHT];
    t_row          r_rdata;
    t_row          r_row_c;
    t_row          r_row_u1;
    t_row          r_row_u2;
    t_row          r_row_d1;
    t_row          r_row_d2;
    logic [AW-1:0] r_clr;

    // step decision
    logic [2:0] r_status;
    logic [1:0] r_dir;
    logic       r_multi;

    // result register
    logic       r_out_valid;
    logic [2:0] r_o_status;
    logic [5:0] r_o_row;
    logic [5:0] r_o_col;
    logic [1:0] r_o_dir;
    logic       r_o_wall;

    logic [XW-1:0] r9;
    logic [XW-1:0] c9;
    logic [XW-1:0] h9;
    logic [XW-1:0] w9;
    logic [XW-1:0] rd_addr9;
    logic [3:0]    legal;
    logic [2:0]    n_cnt;
    logic [1:0]    pick;
    logic [1:0]    sel_dir;
    logic [1:0]    cnt;
    logic          map_we;
    logic [AW-1:0] map_waddr;
    t_row          map_wdata;
    logic [PW-1:0] new_row;
    logic [PW-1:0] new_col;
    logic          rd_wall;
    logic          rd_in_range;

    assign r9 = XW'(r_cur_row);
    assign c9 = XW'(r_cur_col);
    assign h9 = (XW'(r_maze_height) > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT)
                                                       : XW'(r_maze_height);
    assign w9 = (XW'(r_maze_width) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH)
                                                     : XW'(r_maze_width);

    always_comb begin
        case (i_cmd.rd_sel)
            mdg_pkg::RSEL_U1: rd_addr9 = r9 - XW'(1);
            mdg_pkg::RSEL_U2: rd_addr9 = r9 - XW'(2);
            mdg_pkg::RSEL_D1: rd_addr9 = r9 + XW'(1);
            mdg_pkg::RSEL_D2: rd_addr9 = r9 + XW'(2);
            mdg_pkg::RSEL_Q:  rd_addr9 = XW'(r_rd_row);
            default:          rd_addr9 = r9;
        endcase
    end

    // legal two-cell moves in the order up, down, left, right
    assign legal[0] = (r9 >= XW'(3)) && wall_at(r_row_u1, c9) && wall_at(r_row_u2, c9);
    assign legal[1] = (r9 + XW'(2) < h9) && wall_at(r_row_d1, c9)
                      && wall_at(r_row_d2, c9);
    assign legal[2] = (c9 >= XW'(3)) && wall_at(r_row_c, c9 - XW'(1))
                      && wall_at(r_row_c, c9 - XW'(2));
    assign legal[3] = (c9 + XW'(2) < w9) && wall_at(r_row_c, c9 + XW'(1))
                      && wall_at(r_row_c, c9 + XW'(2));
    assign n_cnt = 3'($countones(legal));

    always_comb begin
        case (n_cnt)
            3'd1:    pick = 2'd0;
            3'd2:    pick = {1'b0, r_rnd[0]};
            3'd3:    pick = mod3(r_rnd);
            default: pick = r_rnd[1:0];
        endcase
        sel_dir = mdg_pkg::DIR_UP;
        cnt     = 2'd0;
        for (int d = 0; d < 4; d++) begin
            if (legal[d]) begin
                if (cnt == pick) begin
                    sel_dir = 2'(d);
                end
                cnt = cnt + 2'd1;
            end
        end
    end

    always_comb begin
        new_row = r_cur_row;
        new_col = r_cur_col;
        case (r_dir)
            mdg_pkg::DIR_UP:   new_row = r_cur_row - PW'(2);
            mdg_pkg::DIR_DOWN: new_row = r_cur_row + PW'(2);
            mdg_pkg::DIR_LEFT: new_col = r_cur_col - PW'(2);
            default:           new_col = r_cur_col + PW'(2);
        endcase
    end

    // map write port
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_clr;
        map_wdata = '1;
        if (i_cmd.clr_row) begin
            map_we = 1'b1;
        end else if (i_cmd.start_wr) begin
            map_we    = 1'b1;
            map_waddr = AW'(1);
            map_wdata = open_at('1, XW'(1));
        end else if (i_cmd.carve1) begin
            map_we = 1'b1;
            case (r_dir)
                mdg_pkg::DIR_UP: begin
                    map_waddr = AW'(r9 - XW'(1));
                    map_wdata = open_at(r_row_u1, c9);
                end
                mdg_pkg::DIR_DOWN: begin
                    map_waddr = AW'(r9 + XW'(1));
                    map_wdata = open_at(r_row_d1, c9);
                end
                mdg_pkg::DIR_LEFT: begin
                    map_waddr = AW'(r9);
                    map_wdata = open_at(open_at(r_row_c, c9 - XW'(1)), c9 - XW'(2));
                end
                default: begin
                    map_waddr = AW'(r9);
                    map_wdata = open_at(open_at(r_row_c, c9 + XW'(1)), c9 + XW'(2));
                end
            endcase
        end else if (i_cmd.carve2) begin
            map_we = 1'b1;
            if (r_dir == mdg_pkg::DIR_UP) begin
                map_waddr = AW'(r9 - XW'(2));
                map_wdata = open_at(r_row_u2, c9);
            end else begin
                map_waddr = AW'(r9 + XW'(2));
                map_wdata = open_at(r_row_d2, c9);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map[map_waddr] <= map_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_map[rd_addr9[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                mdg_pkg::RSEL_U1: r_row_u1 <= r_rdata;
                mdg_pkg::RSEL_U2: r_row_u2 <= r_rdata;
                mdg_pkg::RSEL_D1: r_row_d1 <= r_rdata;
                mdg_pkg::RSEL_D2: r_row_d2 <= r_rdata;
                default:          r_row_c  <= r_rdata;
            endcase
        end
    end

    // branch stack
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_wr) begin
            r_stack[0] <= {PW'(1), PW'(1)};
        end else if (i_cmd.move && r_multi && (r_level < LW'(STACK_DEPTH))) begin
            r_stack[r_level[SW-1:0]] <= {new_row, new_col};
        end
        if (i_cmd.pop_rd) begin
            r_stk_rdata <= r_stack[SW'(r_level - LW'(1))];
        end
    end

    // item, decision and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_rnd    <= i_random_value;
            r_rd_row <= i_read_row;
            r_rd_col <= i_read_col;
        end
        if (i_cmd.decide) begin
            r_dir   <= (legal == 4'd0) ? mdg_pkg::DIR_UP : sel_dir;
            r_multi <= (n_cnt > 3'd1);
        end else if (i_cmd.load_item) begin
            r_dir <= mdg_pkg::DIR_UP;
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_row    <= r_cur_row;
            r_o_col    <= r_cur_col;
            r_o_dir    <= r_dir;
            r_o_wall   <= (r_status == mdg_pkg::ST_READ) ? rd_wall : 1'b0;
        end
    end

    assign rd_in_range = (XW'(r_rd_row) < XW'(MAX_HEIGHT))
                         && (XW'(r_rd_col) < XW'(MAX_WIDTH));
    assign rd_wall     = rd_in_range ? wall_at(r_row_c, XW'(r_rd_col)) : 1'b1;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_maze_width  <= mdg_pkg::CFG_W'(31);
            r_maze_height <= mdg_pkg::CFG_W'(31);
            r_cur_row     <= PW'(1);
            r_cur_col     <= PW'(1);
            r_level       <= '0;
            r_clr         <= '0;
            r_status      <= mdg_pkg::ST_FINISHED;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == mdg_pkg::CFG_IDX_WIDTH) begin
                    r_maze_width <= i_cfg_wdata;
                end else begin
                    r_maze_height <= i_cfg_wdata;
                end
            end
            if (i_cmd.clr_row) begin
                r_clr <= (r_clr == AW'(MAX_HEIGHT - 1)) ? '0 : r_clr + AW'(1);
            end
            // a step stays finished unless it carves or backtracks
            if (i_cmd.load_item) begin
                case (i_opcode)
                    mdg_pkg::OP_START: r_status <= mdg_pkg::ST_STARTED;
                    mdg_pkg::OP_STEP:  r_status <= mdg_pkg::ST_FINISHED;
                    default:           r_status <= mdg_pkg::ST_READ;
                endcase
            end
            if (i_cmd.start_wr) begin
                r_cur_row <= PW'(1);
                r_cur_col <= PW'(1);
                r_level   <= LW'(1);
                r_status  <= mdg_pkg::ST_STARTED;
            end
            if (i_cmd.move) begin
                r_cur_row <= new_row;
                r_cur_col <= new_col;
                r_status  <= mdg_pkg::ST_CARVED;
                if (r_multi && (r_level < LW'(STACK_DEPTH))) begin
                    r_level <= r_level + LW'(1);
                end
            end
            if (i_cmd.pop_rd) begin
                r_level <= r_level - LW'(1);
            end
            if (i_cmd.pop_wr) begin
                r_cur_row <= r_stk_rdata[2*PW-1:PW];
                r_cur_col <= r_stk_rdata[PW-1:0];
                r_status  <= mdg_pkg::ST_BACKTRACK;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.level_zero = (r_level == '0);
    assign o_stat.clr_last   = (r_clr == AW'(MAX_HEIGHT - 1));
    assign o_stat.no_move    = (legal == 4'd0);
    assign o_stat.vertical   = ~r_dir[1];
    assign o_stat.out_busy   = r_out_valid & ~i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_digger_row   = r_o_row;
    assign o_digger_col   = r_o_col;
    assign o_move_dir     = r_o_dir;
    assign o_cell_is_wall = r_o_wall;

endmodule

[design/maze_dig_generator.sv]
// ----------------------------------------------------------------------------
// maze_dig_generator
// Randomised depth-first maze carver over a row-organised wall map.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  i_item   | in  | valid/ready   | opcode, random_value, read_row, read_col
//  o_result | out | valid/ready   | status, digger_row, digger_col, move_dir,
//           |     |               | cell_is_wall
//  cfg      | in  | i_cfg_we      | i_cfg_idx (0 width, 1 height), i_cfg_wdata
//
//  One transaction in at a time: the next is accepted once the last has loaded
//  its result. A carving step does five map row reads on the single read port,
//  a decide, two row writes (one when the carve is sideways), a move and the
//  result; a backtrack pops the stack, an empty-stack step goes to its result,
//  a read does one row read, a start clears each row (one row cleared a cycle).
//  After reset a clearing pass over all MAX_HEIGHT rows runs before the first
//  transaction is accepted; configuration writes are taken throughout.
//  The result register lets the next transaction enter while a result waits;
//  the following result holds in the datapath until o_result is free.
// ----------------------------------------------------------------------------
module maze_dig_generator #(
    parameter int MAX_WIDTH   = 64,
    parameter int MAX_HEIGHT  = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    mdg_in_if.sink                    i_item,
    mdg_out_if.source                 o_result,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [mdg_pkg::CFG_W-1:0] i_cfg_wdata
);

    mdg_pkg::t_dp_cmd  cmd;
    mdg_pkg::t_dp_stat stat;
    logic              in_ready;

    assign i_item.ready = in_ready;

    // sequencer: owns the input handshake
    mdg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_opcode   (i_item.opcode),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // map, stack, digger and the result register
    mdg_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (i_item.opcode),
        .i_random_value (i_item.random_value),
        .i_read_row     (i_item.read_row),
        .i_read_col     (i_item.read_col),
        .o_out_valid    (o_result.valid),
        .i_out_ready    (o_result.ready),
        .o_status       (o_result.status),
        .o_digger_row   (o_result.digger_row),
        .o_digger_col   (o_result.digger_col),
        .o_move_dir     (o_result.move_dir),
        .o_cell_is_wall (o_result.cell_is_wall)
    );

endmodule

[tb/sv/maze_dig_generator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_dig_generator_tb
// Self-checking bench for the maze carver: a queue-fed driver offers start,
// step and read transactions with random stalls, a monitor compares every
// result with a cycle-free model of the digger, its wall map and stack.
// ----------------------------------------------------------------------------
module maze_dig_generator_tb;

    localparam int MAP_ROWS   = 64;
    localparam int MAP_COLS   = 64;
    localparam int STACK_SIZE = 1024;
    localparam int DRAIN_WAIT = MAP_ROWS + 40;  // a start outlasts everything else
    localparam int STALL_LIMIT = 4000;          // cycles with no transaction at all
    localparam int SQUEEZE_LEN = 300;           // long hold-off on the result side
    localparam int OP_ODD     = 3;              // unused opcode, behaves as a read

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] rnd;
        logic [5:0]  row;
        logic [5:0]  col;
    } dig_cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] row;
        logic [5:0] col;
        logic [1:0] dir;
        logic       wall;
    } dig_res_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_idx;
    logic [mdg_pkg::CFG_W-1:0] i_cfg_wdata;

    mdg_in_if  item_ch ();
    mdg_out_if res_ch ();

    maze_dig_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_ch.sink),
        .o_result    (res_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Model state: wall bitmap, branch stack, digger and size registers
    // ------------------------------------------------------------------
    bit       wall_map [MAP_ROWS][MAP_COLS];
    int       branch_row [STACK_SIZE];
    int       branch_col [STACK_SIZE];
    int       branch_lvl;
    int       dig_row, dig_col;
    int       size_w, size_h;

    dig_cmd_t pending_cmds[$];
    dig_res_t expected_res[$];

    int  n_fail, n_in, n_out, idle_cycles;
    int  n_started, n_carved, n_backtr, n_done, n_reads;
    bit  took;          // driver's current transaction went in at the last edge
    bit  calm;          // no random idling on either side
    bit  squeezed;      // the long hold-off has been done
    int  hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit cell_wall(int r, int c);
        if (r >= MAP_ROWS || c >= MAP_COLS || r < 0 || c < 0)
            return 1'b1;
        return wall_map[r][c];
    endfunction

    function automatic void open_at(int r, int c);
        if (r >= 0 && r < MAP_ROWS && c >= 0 && c < MAP_COLS)
            wall_map[r][c] = 1'b0;
    endfunction

    function automatic void fill_walls();
        foreach (wall_map[r, c]) wall_map[r][c] = 1'b1;
    endfunction

    // Work out the single result a transaction produces and update the model.
    function automatic dig_res_t predict_dig(dig_cmd_t cmd);
        dig_res_t res;
        int moves[4];
        int n, w, h, r, c, pick;
        res = '0;
        n = 0;
        if (cmd.opcode == mdg_pkg::OP_START) begin
            fill_walls();
            dig_row = 1;
            dig_col = 1;
            open_at(1, 1);
            branch_row[0] = 1;
            branch_col[0] = 1;
            branch_lvl = 1;
            res.status = mdg_pkg::ST_STARTED;
        end else if (cmd.opcode == mdg_pkg::OP_STEP) begin
            if (branch_lvl == 0) begin
                res.status = mdg_pkg::ST_FINISHED;
            end else begin
                w = (size_w > MAP_COLS) ? MAP_COLS : size_w;
                h = (size_h > MAP_ROWS) ? MAP_ROWS : size_h;
                r = dig_row;
                c = dig_col;
                if (r >= 3 && cell_wall(r - 1, c) && cell_wall(r - 2, c))
                    moves[n++] = mdg_pkg::DIR_UP;
                if (r + 2 < h && cell_wall(r + 1, c) && cell_wall(r + 2, c))
                    moves[n++] = mdg_pkg::DIR_DOWN;
                if (c >= 3 && cell_wall(r, c - 1) && cell_wall(r, c - 2))
                    moves[n++] = mdg_pkg::DIR_LEFT;
                if (c + 2 < w && cell_wall(r, c + 1) && cell_wall(r, c + 2))
                    moves[n++] = mdg_pkg::DIR_RIGHT;
                if (n == 0) begin
                    branch_lvl--;
                    dig_row = branch_row[branch_lvl];
                    dig_col = branch_col[branch_lvl];
                    res.status = mdg_pkg::ST_BACKTRACK;
                end else begin
                    pick = moves[int'(cmd.rnd) % n];
                    case (pick)
                        mdg_pkg::DIR_UP: begin
                            open_at(r - 1, c); open_at(r - 2, c); r -= 2;
                        end
                        mdg_pkg::DIR_DOWN: begin
                            open_at(r + 1, c); open_at(r + 2, c); r += 2;
                        end
                        mdg_pkg::DIR_LEFT: begin
                            open_at(r, c - 1); open_at(r, c - 2); c -= 2;
                        end
                        default: begin
                            open_at(r, c + 1); open_at(r, c + 2); c += 2;
                        end
                    endcase
                    dig_row = r;
                    dig_col = c;
                    // only branch points go on the stack; a full stack drops it
                    if (n > 1 && branch_lvl < STACK_SIZE) begin
                        branch_row[branch_lvl] = r;
                        branch_col[branch_lvl] = c;
                        branch_lvl++;
                    end
                    res.dir    = pick[1:0];
                    res.status = mdg_pkg::ST_CARVED;
                end
            end
        end else begin
            // read, and the spare opcode acts the same
            res.wall   = cell_wall(cmd.row, cmd.col);
            res.status = mdg_pkg::ST_READ;
        end
        res.row = dig_row[5:0];
        res.col = dig_col[5:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: falling edge, one transaction held until it is taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n && (!item_ch.valid || took)) begin
            if (pending_cmds.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                dig_cmd_t nxt;
                nxt = pending_cmds.pop_front();
                item_ch.opcode       <= nxt.opcode;
                item_ch.random_value <= nxt.rnd;
                item_ch.read_row     <= nxt.row;
                item_ch.read_col     <= nxt.col;
                item_ch.valid        <= 1'b1;
            end else begin
                item_ch.valid <= 1'b0;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off while items keep coming
    always @(negedge i_clk) begin
        if (!squeezed && n_in >= 200) begin
            squeezed  <= 1'b1;
            hold_left <= SQUEEZE_LEN;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= calm || ($urandom_range(99) >= 34);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: rising edge, predicts on input and checks on output
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        dig_cmd_t cmd;
        dig_res_t want, got;
        bit moved;
        moved = 1'b0;
        took <= i_rst_n && item_ch.valid && item_ch.ready;
        if (i_rst_n && item_ch.valid && item_ch.ready) begin
            cmd.opcode = item_ch.opcode;
            cmd.rnd    = item_ch.random_value;
            cmd.row    = item_ch.read_row;
            cmd.col    = item_ch.read_col;
            expected_res.insert(expected_res.size(), predict_dig(cmd));
            n_in++;
            moved = 1'b1;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.status = res_ch.status;
            got.row    = res_ch.digger_row;
            got.col    = res_ch.digger_col;
            got.dir    = res_ch.move_dir;
            got.wall   = res_ch.cell_is_wall;
            moved = 1'b1;
            n_out++;
            if (expected_res.size() == 0) begin
                $display("%0t: result with nothing pending: status %0d row %0d col %0d",
                         $time, got.status, got.row, got.col);
                n_fail++;
            end else begin
                want = expected_res.pop_front();
                case (got.status)
                    mdg_pkg::ST_STARTED:   n_started++;
                    mdg_pkg::ST_CARVED:    n_carved++;
                    mdg_pkg::ST_BACKTRACK: n_backtr++;
                    mdg_pkg::ST_FINISHED:  n_done++;
                    default:               n_reads++;
                endcase
                if (got.status != want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    n_fail++;
                end
                if (got.row != want.row) begin
                    $display("%0t: digger_row expected %0d actual %0d",
                             $time, want.row, got.row);
                    n_fail++;
                end
                if (got.col != want.col) begin
                    $display("%0t: digger_col expected %0d actual %0d",
                             $time, want.col, got.col);
                    n_fail++;
                end
                if (got.dir != want.dir) begin
                    $display("%0t: move_dir expected %0d actual %0d",
                             $time, want.dir, got.dir);
                    n_fail++;
                end
                if (got.wall != want.wall) begin
                    $display("%0t: cell_is_wall expected %0d actual %0d",
                             $time, want.wall, got.wall);
                    n_fail++;
                end
            end
        end
        // watchdog: the clearing pass after reset and a start fit well inside
        if (!i_rst_n || moved) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic dig_cmd_t mk_cmd(int op, int rnd, int r, int c);
        dig_cmd_t cmd;
        cmd.opcode = op[1:0];
        cmd.rnd    = rnd[15:0];
        cmd.row    = r[5:0];
        cmd.col    = c[5:0];
        return cmd;
    endfunction

    function automatic void add_cmd(dig_cmd_t cmd);
        pending_cmds.insert(pending_cmds.size(), cmd);
    endfunction

    // Mostly well-formed digging: steps with random words, reads now and then
    function automatic void queue_dig_run(int count, bit with_start);
        int roll;
        if (with_start)
            add_cmd(mk_cmd(mdg_pkg::OP_START, $urandom, 0, 0));
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 74)
                add_cmd(mk_cmd(mdg_pkg::OP_STEP, $urandom_range(65535), 0, 0));
            else if (roll < 90)
                add_cmd(mk_cmd(mdg_pkg::OP_READ, $urandom,
                               $urandom_range(63), $urandom_range(63)));
            else if (roll < 95)
                add_cmd(mk_cmd(mdg_pkg::OP_READ, $urandom,
                               $urandom_range(8), $urandom_range(8)));
            else if (roll < 98)
                add_cmd(mk_cmd(OP_ODD, $urandom,
                               $urandom_range(63), $urandom_range(63)));
            else
                add_cmd(mk_cmd(mdg_pkg::OP_START, $urandom, 0, 0));
        end
    endfunction

    task automatic drain();
        do @(posedge i_clk);
        while (pending_cmds.size() > 0 || item_ch.valid || expected_res.size() > 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_size(int w, int h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= mdg_pkg::CFG_IDX_WIDTH;
        i_cfg_wdata <= w[mdg_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_idx   <= mdg_pkg::CFG_IDX_HEIGHT;
        i_cfg_wdata <= h[mdg_pkg::CFG_W-1:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        size_w = w;
        size_h = h;
    endtask

    initial begin
        item_ch.valid        = 1'b0;
        item_ch.opcode       = mdg_pkg::OP_START;
        item_ch.random_value = '0;
        item_ch.read_row     = '0;
        item_ch.read_col     = '0;
        res_ch.ready         = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = mdg_pkg::CFG_IDX_WIDTH;
        i_cfg_wdata = '0;
        i_rst_n     = 1'b0;
        took        = 1'b0;
        calm        = 1'b0;
        squeezed    = 1'b0;
        hold_left   = 0;
        {n_fail, n_in, n_out, idle_cycles} = '0;
        {n_started, n_carved, n_backtr, n_done, n_reads} = '0;
        fill_walls();
        branch_lvl = 0;
        dig_row = 1;
        dig_col = 1;
        size_w = 31;
        size_h = 31;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a step on an empty stack, reads of corners, the spare opcode,
        // then a fresh maze dug with extreme random words.
        add_cmd(mk_cmd(mdg_pkg::OP_STEP, 16'hFFFF, 0, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_READ, 0, 0, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_READ, 0, 63, 63));
        add_cmd(mk_cmd(OP_ODD, 16'hFFFF, 63, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_START, 0, 63, 63));
        add_cmd(mk_cmd(mdg_pkg::OP_READ, 0, 1, 1));
        add_cmd(mk_cmd(mdg_pkg::OP_STEP, 0, 0, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_STEP, 16'hFFFF, 0, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_STEP, 16'h5555, 0, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_STEP, 16'hAAAA, 0, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_READ, 0, 1, 2));
        add_cmd(mk_cmd(mdg_pkg::OP_READ, 0, 2, 1));
        add_cmd(mk_cmd(OP_ODD, 0, 0, 63));
        drain();

        // Smallest legal grid: dug out fast, then backtracks and finishes
        set_size(5, 5);
        add_cmd(mk_cmd(mdg_pkg::OP_START, 0, 0, 0));
        repeat (8) add_cmd(mk_cmd(mdg_pkg::OP_STEP, $urandom, 0, 0));
        add_cmd(mk_cmd(mdg_pkg::OP_READ, 0, 3, 3));
        drain();

        // Oversized registers saturate at the stored grid; a quiet stretch here
        set_size(127, 127);
        calm = 1'b1;
        queue_dig_run(110, 1'b1);
        drain();
        calm = 1'b0;

        // Sizes below the minimum: few or no moves
        set_size(0, 4);
        queue_dig_run(30, 1'b1);
        drain();

        // Wide and flat, deep enough to run the stack down to finished
        set_size(64, 9);
        queue_dig_run(160, 1'b1);
        drain();

        // Shrink under a half-dug maze without restarting
        set_size(7, 7);
        queue_dig_run(40, 1'b0);
        drain();

        // Middle sizes at random, mostly smallish
        repeat (3) begin
            set_size($urandom_range(5, 24), $urandom_range(5, 24));
            queue_dig_run(90, 1'b1);
            drain();
        end
        set_size($urandom_range(5, 64), $urandom_range(5, 64));
        queue_dig_run(110, 1'b1);
        drain();

        $display("Covered %0d transactions: %0d starts, %0d carves, %0d backtracks,",
                 n_in, n_started, n_carved, n_backtr);
        $display("  %0d steps on an empty stack and %0d cell reads over several grid sizes",
                 n_done, n_reads);
        if (n_fail == 0 && expected_res.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
